/* rtl/core/star_vertex_generator_core_macros.svh */
// Assertion helpers used by the RTL file that carries checks.
// Each macro expects a clock named clk and an active-low reset named rst_n.
`ifndef STAR_VERTEX_GENERATOR_CORE_MACROS_SVH
`define STAR_VERTEX_GENERATOR_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SVG_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("star vertex generator check failed");

// Consequent must hold in the cycle after the antecedent.
`define SVG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("star vertex generator check failed");

`endif

/* rtl/core/svg_pkg.sv */
package svg_pkg;

    // Field and register widths.
    localparam int COORD_WIDTH  = 16;
    localparam int RADIUS_WIDTH = 15;
    localparam int COUNT_WIDTH  = 5;
    localparam int INDEX_WIDTH  = 6;
    localparam int ANGLE_WIDTH  = 16;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 16;

    // Tip count limit and CORDIC defaults.
    localparam int MAX_POINTS = 31;
    localparam int CORDIC_ITERATIONS_DEFAULT = 16;
    localparam int ATAN_LEN = 30;
    localparam int ATAN_INDEX_WIDTH = 5;

    // Datapath widths: x/y carry 16 bits below the coordinate LSB, z uses 2^32 per turn.
    localparam int XY_WIDTH   = 34;
    localparam int Z_WIDTH    = 32;
    localparam int PROD_WIDTH = 45;
    localparam int OFS_WIDTH  = COORD_WIDTH + 2;

    // CORDIC gain 0.6072529350 in Q0.30.
    localparam logic [29:0] GAIN_Q30 = 30'd652032874;
    localparam logic [ANGLE_WIDTH-1:0] START_BAU = 16'hC000;
    localparam logic [ANGLE_WIDTH-1:0] QUARTER_HALF_BAU = 16'h2000;

    // Register reset values.
    localparam logic [RADIUS_WIDTH-1:0] OUTER_RADIUS_RESET = 15'd22938;
    localparam logic [RADIUS_WIDTH-1:0] INNER_RADIUS_RESET = 15'd9175;
    localparam logic [COUNT_WIDTH-1:0]  POINT_COUNT_RESET  = 5'd5;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_CENTER_X     = 3'd0,
        CFG_CENTER_Y     = 3'd1,
        CFG_OUTER_RADIUS = 3'd2,
        CFG_INNER_RADIUS = 3'd3,
        CFG_POINT_COUNT  = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] center_x;
        logic signed [COORD_WIDTH-1:0] center_y;
        logic [RADIUS_WIDTH-1:0]       outer_radius;
        logic [RADIUS_WIDTH-1:0]       inner_radius;
        logic [COUNT_WIDTH-1:0]        point_count;
    } cfg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;
        logic load_center;
        logic init_rim;
        logic rotate;
        logic post;
        logic push_rim;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic slot_free;
        logic iter_done;
        logic rim_last;
    } sts_t;

    // Arctangent of 2^-i in 2^32-per-turn units.
    function automatic logic [29:0] atan_entry(input logic [ATAN_INDEX_WIDTH-1:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:  v = 30'h20000000;
            5'd1:  v = 30'h12E4051E;
            5'd2:  v = 30'h09FB385B;
            5'd3:  v = 30'h051111D4;
            5'd4:  v = 30'h028B0D43;
            5'd5:  v = 30'h0145D7E1;
            5'd6:  v = 30'h00A2F61E;
            5'd7:  v = 30'h00517C55;
            5'd8:  v = 30'h0028BE53;
            5'd9:  v = 30'h00145F2F;
            5'd10: v = 30'h000A2F98;
            5'd11: v = 30'h000517CC;
            5'd12: v = 30'h00028BE6;
            5'd13: v = 30'h000145F3;
            5'd14: v = 30'h0000A2FA;
            5'd15: v = 30'h0000517D;
            5'd16: v = 30'h000028BE;
            5'd17: v = 30'h0000145F;
            5'd18: v = 30'h00000A30;
            5'd19: v = 30'h00000518;
            5'd20: v = 30'h0000028C;
            5'd21: v = 30'h00000146;
            5'd22: v = 30'h000000A3;
            5'd23: v = 30'h00000051;
            5'd24: v = 30'h00000029;
            5'd25: v = 30'h00000014;
            5'd26: v = 30'h0000000A;
            5'd27: v = 30'h00000005;
            5'd28: v = 30'h00000003;
            5'd29: v = 30'h00000001;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Angle step round(65536 / (2 * points)) for each tip count.
    function automatic logic [ANGLE_WIDTH-1:0] step_entry(input logic [COUNT_WIDTH-1:0] pts);
        logic [ANGLE_WIDTH-1:0] v;
        case (pts)
            5'd1:  v = 16'd32768;
            5'd2:  v = 16'd16384;
            5'd3:  v = 16'd10923;
            5'd4:  v = 16'd8192;
            5'd5:  v = 16'd6554;
            5'd6:  v = 16'd5461;
            5'd7:  v = 16'd4681;
            5'd8:  v = 16'd4096;
            5'd9:  v = 16'd3641;
            5'd10: v = 16'd3277;
            5'd11: v = 16'd2979;
            5'd12: v = 16'd2731;
            5'd13: v = 16'd2521;
            5'd14: v = 16'd2341;
            5'd15: v = 16'd2185;
            5'd16: v = 16'd2048;
            5'd17: v = 16'd1928;
            5'd18: v = 16'd1820;
            5'd19: v = 16'd1725;
            5'd20: v = 16'd1638;
            5'd21: v = 16'd1560;
            5'd22: v = 16'd1489;
            5'd23: v = 16'd1425;
            5'd24: v = 16'd1365;
            5'd25: v = 16'd1311;
            5'd26: v = 16'd1260;
            5'd27: v = 16'd1214;
            5'd28: v = 16'd1170;
            5'd29: v = 16'd1130;
            5'd30: v = 16'd1092;
            5'd31: v = 16'd1057;
            default: v = 16'd32768;
        endcase
        return v;
    endfunction

endpackage

/* rtl/core/svg_ctrl.sv */
module svg_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic          request,
    input  svg_pkg::sts_t sts,
    output svg_pkg::cmd_t cmd
);
    import svg_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_CENTER = 6'b000010,
        ST_MUL    = 6'b000100,
        ST_ROT    = 6'b001000,
        ST_POST   = 6'b010000,
        ST_PUSH   = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && request)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_CENTER;
                end
            end
            ST_CENTER:
            begin
                if (sts.slot_free)
                begin
                    cmd.load_center = 1'b1;
                    state_next      = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.init_rim = 1'b1;
                state_next   = ST_ROT;
            end
            ST_ROT:
            begin
                cmd.rotate = 1'b1;
                if (sts.iter_done)
                begin
                    state_next = ST_POST;
                end
            end
            ST_POST:
            begin
                cmd.post   = 1'b1;
                state_next = ST_PUSH;
            end
            ST_PUSH:
            begin
                if (sts.slot_free)
                begin
                    cmd.push_rim = 1'b1;
                    state_next   = sts.rim_last ? ST_IDLE : ST_MUL;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/svg_datapath.sv */
module svg_datapath #(
    parameter int CORDIC_ITERATIONS = svg_pkg::CORDIC_ITERATIONS_DEFAULT
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  svg_pkg::cfg_t                           cfg,
    input  svg_pkg::cmd_t                           cmd,
    output svg_pkg::sts_t                           sts,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [svg_pkg::COORD_WIDTH-1:0]  vertex_x,
    output logic signed [svg_pkg::COORD_WIDTH-1:0]  vertex_y,
    output logic [svg_pkg::INDEX_WIDTH-1:0]         vertex_index,
    output logic                                    last
);
    import svg_pkg::*;

    // Iterations beyond the arctangent table are not used.
    localparam int ITERS  = (CORDIC_ITERATIONS > ATAN_LEN) ? ATAN_LEN : CORDIC_ITERATIONS;
    localparam int ITER_W = (ITERS > 1) ? $clog2(ITERS) : 1;
    localparam int SUM_W  = COORD_WIDTH + 3;

    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } quad_t;

    logic [INDEX_WIDTH-1:0]        segs_reg;
    logic [INDEX_WIDTH-1:0]        rim_reg;
    logic [ANGLE_WIDTH-1:0]        step_reg;
    logic [ANGLE_WIDTH-1:0]        acc_reg;
    logic [ITER_W-1:0]             iter_reg;
    logic signed [XY_WIDTH-1:0]    x_reg;
    logic signed [XY_WIDTH-1:0]    y_reg;
    logic signed [Z_WIDTH-1:0]     z_reg;
    quad_t                         quad_reg;
    logic signed [OFS_WIDTH-1:0]   dx_reg;
    logic signed [OFS_WIDTH-1:0]   dy_reg;
    logic                          out_valid_reg;
    logic signed [COORD_WIDTH-1:0] vx_reg;
    logic signed [COORD_WIDTH-1:0] vy_reg;
    logic [INDEX_WIDTH-1:0]        vidx_reg;
    logic                          last_reg;

    logic [COUNT_WIDTH-1:0]        pts;
    logic                          rim_last;
    logic [RADIUS_WIDTH-1:0]       radius;
    logic [ANGLE_WIDTH-1:0]        angle;
    logic [ANGLE_WIDTH-1:0]        z16;
    logic [PROD_WIDTH-1:0]         prod;
    logic [PROD_WIDTH-1:0]         prod_rnd;
    logic signed [XY_WIDTH-1:0]    shx;
    logic signed [XY_WIDTH-1:0]    shy;
    logic signed [Z_WIDTH-1:0]     atan_val;
    logic signed [XY_WIDTH-1:0]    x_rnd;
    logic signed [XY_WIDTH-1:0]    y_rnd;
    logic signed [OFS_WIDTH-1:0]   c_val;
    logic signed [OFS_WIDTH-1:0]   s_val;
    logic signed [OFS_WIDTH-1:0]   dx_val;
    logic signed [OFS_WIDTH-1:0]   dy_val;
    logic signed [SUM_W-1:0]       sum_x;
    logic signed [SUM_W-1:0]       sum_y;

    // Clamp a sum to the signed coordinate range.
    function automatic logic signed [COORD_WIDTH-1:0] sat_coord(
        input logic signed [SUM_W-1:0] v
    );
        logic signed [COORD_WIDTH-1:0] r;
        if ((&v[SUM_W-1:COORD_WIDTH-1]) || !(|v[SUM_W-1:COORD_WIDTH-1]))
        begin
            r = v[COORD_WIDTH-1:0];
        end
        else if (v[SUM_W-1])
        begin
            r = {1'b1, {(COORD_WIDTH-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(COORD_WIDTH-1){1'b1}}};
        end
        return r;
    endfunction

    // Effective tip count: zero acts as one, the limit caps the rest.
    always_comb
    begin
        if (cfg.point_count == '0)
        begin
            pts = COUNT_WIDTH'(1);
        end
        else if (cfg.point_count > COUNT_WIDTH'(MAX_POINTS))
        begin
            pts = COUNT_WIDTH'(MAX_POINTS);
        end
        else
        begin
            pts = cfg.point_count;
        end
    end

    // Start vector and angle setup for the current rim vertex.
    assign rim_last = (rim_reg == segs_reg);
    assign radius   = rim_reg[0] ? cfg.inner_radius : cfg.outer_radius;
    assign angle    = rim_last ? START_BAU : acc_reg;
    assign z16      = angle + QUARTER_HALF_BAU;
    assign prod     = PROD_WIDTH'(radius) * PROD_WIDTH'(GAIN_Q30);
    assign prod_rnd = prod + PROD_WIDTH'(1 << 13);

    // One CORDIC micro-rotation.
    assign shx      = y_reg >>> iter_reg;
    assign shy      = x_reg >>> iter_reg;
    assign atan_val = $signed({2'b00, atan_entry(ATAN_INDEX_WIDTH'(iter_reg))});

    // Round to coordinate LSBs and unfold the quadrant.
    assign x_rnd = x_reg + XY_WIDTH'(32768);
    assign y_rnd = y_reg + XY_WIDTH'(32768);
    assign c_val = x_rnd[XY_WIDTH-1:16];
    assign s_val = y_rnd[XY_WIDTH-1:16];

    always_comb
    begin
        case (quad_reg)
            QUAD_0:
            begin
                dx_val = c_val;
                dy_val = s_val;
            end
            QUAD_1:
            begin
                dx_val = -s_val;
                dy_val = c_val;
            end
            QUAD_2:
            begin
                dx_val = -c_val;
                dy_val = -s_val;
            end
            default:
            begin
                dx_val = s_val;
                dy_val = -c_val;
            end
        endcase
    end

    // Offset from the center.
    assign sum_x = SUM_W'(cfg.center_x) + SUM_W'(dx_reg);
    assign sum_y = SUM_W'(cfg.center_y) + SUM_W'(dy_reg);

    // Run counters and CORDIC registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            segs_reg <= '0;
            rim_reg  <= '0;
            step_reg <= '0;
            acc_reg  <= '0;
            iter_reg <= '0;
        end
        else
        begin
            if (cmd.start)
            begin
                segs_reg <= {pts, 1'b0};
                step_reg <= step_entry(pts);
                acc_reg  <= START_BAU;
                rim_reg  <= '0;
            end
            if (cmd.init_rim)
            begin
                iter_reg <= '0;
            end
            if (cmd.rotate)
            begin
                iter_reg <= iter_reg + ITER_W'(1);
            end
            if (cmd.push_rim)
            begin
                acc_reg <= acc_reg + step_reg;
                rim_reg <= rim_last ? '0 : rim_reg + INDEX_WIDTH'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.init_rim)
        begin
            quad_reg <= quad_t'(z16[15:14]);
            z_reg    <= {{2{~z16[13]}}, ~z16[13], z16[12:0], 16'h0000};
            x_reg    <= $signed({3'b000, prod_rnd[44:14]});
            y_reg    <= '0;
        end
        else if (cmd.rotate)
        begin
            if (!z_reg[Z_WIDTH-1])
            begin
                x_reg <= x_reg - shx;
                y_reg <= y_reg + shy;
                z_reg <= z_reg - atan_val;
            end
            else
            begin
                x_reg <= x_reg + shx;
                y_reg <= y_reg - shy;
                z_reg <= z_reg + atan_val;
            end
        end
        if (cmd.post)
        begin
            dx_reg <= dx_val;
            dy_reg <= dy_val;
        end
    end

    // Output register: holds one vertex until the receiver takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_center || cmd.push_rim)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_center)
        begin
            vx_reg   <= cfg.center_x;
            vy_reg   <= cfg.center_y;
            vidx_reg <= '0;
            last_reg <= 1'b0;
        end
        else if (cmd.push_rim)
        begin
            vx_reg   <= sat_coord(sum_x);
            vy_reg   <= sat_coord(sum_y);
            vidx_reg <= rim_reg + INDEX_WIDTH'(1);
            last_reg <= rim_last;
        end
    end

    assign sts.slot_free = !out_valid_reg || out_ready;
    assign sts.iter_done = (iter_reg == ITER_W'(ITERS - 1));
    assign sts.rim_last  = rim_last;

    assign out_valid    = out_valid_reg;
    assign vertex_x     = vx_reg;
    assign vertex_y     = vy_reg;
    assign vertex_index = vidx_reg;
    assign last         = last_reg;

endmodule

/* rtl/core/star_vertex_generator_core.sv */
// Star vertex generator.
// Input channel (in_valid/in_ready, request): a request with request = 1 starts one
// run of vertices for a triangle-fan star; a request with request = 0 is taken and
// produces nothing. A new request is taken only when the previous run is fully issued.
// Output channel (out_valid/out_ready): the center vertex (index 0), then 2*P+1 rim
// vertices, the last one repeating the first and marked by last.
// Configuration: cfg_we writes cfg_wdata into register cfg_index (center x, center y,
// outer radius, inner radius, tip count); write only while no run is in progress.
// Timing: the request moves the sequencer to its CENTER state, which loads the center
// vertex into the output register. Each rim vertex passes through the single shared
// iterative CORDIC rotator: a setup step with the gain multiply, one micro-rotation per
// cycle, a rounding step and an output step.
// A single output register holds each vertex; the next vertex is computed while it
// waits, and the rotator stalls only when a finished vertex finds the register full.
// Reset clears the run, empties the output register and restores the register defaults.
`include "star_vertex_generator_core_macros.svh"

module star_vertex_generator_core #(
    parameter int CORDIC_ITERATIONS = svg_pkg::CORDIC_ITERATIONS_DEFAULT
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic [svg_pkg::CFG_INDEX_WIDTH-1:0]     cfg_index,
    input  logic [svg_pkg::CFG_DATA_WIDTH-1:0]      cfg_wdata,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic                                    request,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [svg_pkg::COORD_WIDTH-1:0]  vertex_x,
    output logic signed [svg_pkg::COORD_WIDTH-1:0]  vertex_y,
    output logic [svg_pkg::INDEX_WIDTH-1:0]         vertex_index,
    output logic                                    last
);
    import svg_pkg::*;

    cfg_t cfg_reg;
    cmd_t cmd;
    sts_t sts;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.center_x     <= '0;
            cfg_reg.center_y     <= '0;
            cfg_reg.outer_radius <= OUTER_RADIUS_RESET;
            cfg_reg.inner_radius <= INNER_RADIUS_RESET;
            cfg_reg.point_count  <= POINT_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CENTER_X:     cfg_reg.center_x     <= cfg_wdata;
                CFG_CENTER_Y:     cfg_reg.center_y     <= cfg_wdata;
                CFG_OUTER_RADIUS: cfg_reg.outer_radius <= cfg_wdata[RADIUS_WIDTH-1:0];
                CFG_INNER_RADIUS: cfg_reg.inner_radius <= cfg_wdata[RADIUS_WIDTH-1:0];
                CFG_POINT_COUNT:  cfg_reg.point_count  <= cfg_wdata[COUNT_WIDTH-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Sequencer.
    svg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .request  (request),
        .sts      (sts),
        .cmd      (cmd)
    );

    // CORDIC and output datapath.
    svg_datapath #(
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .cmd          (cmd),
        .sts          (sts),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .vertex_x     (vertex_x),
        .vertex_y     (vertex_y),
        .vertex_index (vertex_index),
        .last         (last)
    );

    // Checks on the sequencing.
    `SVG_ASSERT_SAME(a_idle_no_work, in_ready, !(cmd.init_rim || cmd.rotate || cmd.post))
    `SVG_ASSERT_SAME(a_load_needs_slot, cmd.load_center || cmd.push_rim, sts.slot_free)
    `SVG_ASSERT_NEXT(a_busy_after_start, in_valid && in_ready && request, !in_ready)
    `SVG_ASSERT_SAME(a_center_not_last, out_valid && (vertex_index == '0), !last)

endmodule
